### hdl/u16550_pkg.sv
// Shared constants, opcode and register codes, and the interrupt status type
// for the 16550-style UART register file. No dependencies.
`timescale 1ns / 1ps
`default_nettype none

package u16550_pkg;

    localparam int RX_DEPTH = 16;
    localparam int TX_DEPTH = 16;

    localparam int RX_PTR_W = (RX_DEPTH > 1) ? $clog2(RX_DEPTH) : 1;
    localparam int RX_CNT_W = $clog2(RX_DEPTH + 1);
    localparam int TX_PTR_W = (TX_DEPTH > 1) ? $clog2(TX_DEPTH) : 1;
    localparam int TX_CNT_W = $clog2(TX_DEPTH + 1);

    typedef enum logic [1:0] {
        OP_READ    = 2'd0,
        OP_WRITE   = 2'd1,
        OP_RX_BYTE = 2'd2,
        OP_TX_TAKE = 2'd3
    } op_t;

    localparam logic [2:0] REG_RBR = 3'd0;  // RBR / THR / DLL
    localparam logic [2:0] REG_IER = 3'd1;  // IER / DLM
    localparam logic [2:0] REG_IIR = 3'd2;  // IIR / FCR
    localparam logic [2:0] REG_LCR = 3'd3;
    localparam logic [2:0] REG_MCR = 3'd4;
    localparam logic [2:0] REG_LSR = 3'd5;
    localparam logic [2:0] REG_MSR = 3'd6;
    localparam logic [2:0] REG_SCR = 3'd7;

    localparam logic [7:0] IIR_NONE      = 8'h01;
    localparam logic [7:0] IIR_ID_MASK   = 8'h0e;
    localparam logic [7:0] IIR_LINE      = 8'h06;
    localparam logic [7:0] IIR_RX        = 8'h04;
    localparam logic [7:0] IIR_THRE      = 8'h02;
    localparam logic [7:0] IIR_FIFO_BITS = 8'hc0;
    localparam logic [7:0] MSR_IDLE      = 8'hb0;

    // IER bit positions
    localparam int IER_RDA  = 0;
    localparam int IER_THRE = 1;
    localparam int IER_RLS  = 2;

    typedef struct packed {
        logic [3:0] ier;
        logic       fifo_en;
        logic       overrun;
        logic       rx_ready;
        logic       thre;
    } irq_status_t;

endpackage

`default_nettype wire

### hdl/u16550_iir.sv
// Interrupt identification: prioritised line status, receive data, THR empty.
// Depends on u16550_pkg.
`timescale 1ns / 1ps
`default_nettype none

module u16550_iir
    import u16550_pkg::*;
(
    input  irq_status_t status,
    output logic [7:0]  iir
);

    logic [7:0] fifo_flags;

    assign fifo_flags = status.fifo_en ? IIR_FIFO_BITS : 8'h00;

    always_comb begin
        if (status.ier[IER_RLS] && status.overrun) begin
            iir = fifo_flags | IIR_LINE;
        end else if (status.ier[IER_RDA] && status.rx_ready) begin
            iir = fifo_flags | IIR_RX;
        end else if (status.ier[IER_THRE] && status.thre) begin
            iir = fifo_flags | IIR_THRE;
        end else begin
            iir = fifo_flags | IIR_NONE;
        end
    end

endmodule

`default_nettype wire

### hdl/uart_16550_register_model.sv
// Top level of the 16550-style UART register file: handshake, register state,
// receive and transmit FIFOs. Depends on u16550_pkg and u16550_iir.
`timescale 1ns / 1ps
`default_nettype none

// Each transaction (register read, register write, received byte, transmitter
// take) gives exactly one result. A transaction is captured in an input
// register, processed by a single pass of decode and FIFO pointer logic once the
// output register is free or being taken, and its result is held in the output
// register until taken. With m_ready held high one transaction is accepted every
// cycle. Both FIFOs are small register arrays; the receive and transmit stores
// have no reset.

module uart_16550_register_model
    import u16550_pkg::*;
(
    input  wire logic       aclk,
    input  wire logic       aresetn,

    input  wire logic       s_valid,
    output logic            s_ready,
    input  wire logic [1:0] s_opcode,
    input  wire logic [2:0] s_reg_index,
    input  wire logic [7:0] s_write_data,
    input  wire logic [7:0] s_rx_byte,

    output logic            m_valid,
    input  wire logic       m_ready,
    output logic [7:0]      m_read_data,
    output logic            m_accepted,
    output logic [7:0]      m_tx_byte,
    output logic            m_tx_valid,
    output logic            m_irq
);

    localparam logic [RX_CNT_W-1:0] RX_CAP_ON  = RX_CNT_W'(RX_DEPTH);
    localparam logic [TX_CNT_W-1:0] TX_CAP_ON  = TX_CNT_W'(TX_DEPTH);
    localparam logic [RX_PTR_W:0]   RX_WRAP    = (RX_PTR_W + 1)'(RX_DEPTH);
    localparam logic [TX_PTR_W:0]   TX_WRAP    = (TX_PTR_W + 1)'(TX_DEPTH);
    localparam logic [RX_PTR_W-1:0] RX_LAST    = RX_PTR_W'(RX_DEPTH - 1);
    localparam logic [TX_PTR_W-1:0] TX_LAST    = TX_PTR_W'(TX_DEPTH - 1);

    // input stage
    logic       in_valid_reg;
    op_t        op_reg;
    logic [2:0] idx_reg;
    logic [7:0] wdata_reg;
    logic [7:0] rxb_reg;

    // output stage
    logic       out_valid_reg;
    logic [7:0] rdata_reg;
    logic       acc_reg;
    logic [7:0] txb_reg;
    logic       txv_reg;
    logic       irq_reg;

    // UART state
    logic [7:0]          rx_mem [RX_DEPTH];
    logic [7:0]          tx_mem [TX_DEPTH];
    logic [RX_PTR_W-1:0] rx_head_reg, rx_head_next;
    logic [RX_CNT_W-1:0] rx_fill_reg, rx_fill_next;
    logic [TX_PTR_W-1:0] tx_head_reg, tx_head_next;
    logic [TX_CNT_W-1:0] tx_fill_reg, tx_fill_next;
    logic [7:0]          dll_reg, dll_next;
    logic [7:0]          dlm_reg, dlm_next;
    logic [3:0]          ier_reg, ier_next;
    logic                fifo_en_reg, fifo_en_next;
    logic [7:0]          lcr_reg, lcr_next;
    logic [4:0]          mcr_reg, mcr_next;
    logic [7:0]          scr_reg, scr_next;
    logic                overrun_reg, overrun_next;
    logic                thre_reg, thre_next;

    logic                advance;
    logic                dlab;
    logic                fcr_toggle;
    logic [RX_CNT_W-1:0] rx_cap;
    logic [TX_CNT_W-1:0] tx_cap;
    logic [RX_PTR_W:0]   rx_tail_sum;
    logic [TX_PTR_W:0]   tx_tail_sum;
    logic [RX_PTR_W-1:0] rx_tail;
    logic [TX_PTR_W-1:0] tx_tail;
    logic [RX_PTR_W-1:0] rx_head_inc;
    logic [TX_PTR_W-1:0] tx_head_inc;
    logic [7:0]          lsr;
    logic [7:0]          msr;
    logic [7:0]          iir_cur;
    logic [7:0]          iir_after;
    irq_status_t         status_cur;
    irq_status_t         status_after;

    logic                rx_we;
    logic                tx_we;
    logic [7:0]          rdata_next;
    logic                acc_next;
    logic [7:0]          txb_next;
    logic                txv_next;

    assign advance = in_valid_reg && (!out_valid_reg || m_ready);
    assign s_ready = !in_valid_reg || advance;

    assign dlab       = lcr_reg[7];
    assign fcr_toggle = fifo_en_reg != wdata_reg[0];
    assign rx_cap     = fifo_en_reg ? RX_CAP_ON : RX_CNT_W'(1);
    assign tx_cap     = fifo_en_reg ? TX_CAP_ON : TX_CNT_W'(1);

    // tail = (head + fill) mod depth; fill stays below depth whenever a push happens
    assign rx_tail_sum = {1'b0, rx_head_reg} + {1'b0, rx_fill_reg[RX_PTR_W-1:0]};
    assign tx_tail_sum = {1'b0, tx_head_reg} + {1'b0, tx_fill_reg[TX_PTR_W-1:0]};
    assign rx_tail = (rx_tail_sum >= RX_WRAP) ? RX_PTR_W'(rx_tail_sum - RX_WRAP)
                                              : rx_tail_sum[RX_PTR_W-1:0];
    assign tx_tail = (tx_tail_sum >= TX_WRAP) ? TX_PTR_W'(tx_tail_sum - TX_WRAP)
                                              : tx_tail_sum[TX_PTR_W-1:0];
    assign rx_head_inc = (rx_head_reg == RX_LAST) ? '0 : rx_head_reg + 1'b1;
    assign tx_head_inc = (tx_head_reg == TX_LAST) ? '0 : tx_head_reg + 1'b1;

    assign lsr = {1'b0, tx_fill_reg == '0, tx_fill_reg == '0, 3'b000,
                  overrun_reg, rx_fill_reg != '0};
    // loopback: RTS->CTS, DTR->DSR, OUT1->RI, OUT2->DCD
    assign msr = mcr_reg[4] ? {mcr_reg[3], mcr_reg[2], mcr_reg[0], mcr_reg[1], 4'b0000}
                            : MSR_IDLE;

    assign status_cur.ier      = ier_reg;
    assign status_cur.fifo_en  = fifo_en_reg;
    assign status_cur.overrun  = overrun_reg;
    assign status_cur.rx_ready = rx_fill_reg != '0;
    assign status_cur.thre     = thre_reg;

    assign status_after.ier      = ier_next;
    assign status_after.fifo_en  = fifo_en_next;
    assign status_after.overrun  = overrun_next;
    assign status_after.rx_ready = rx_fill_next != '0;
    assign status_after.thre     = thre_next;

    u16550_iir u_iir_cur (
        .status (status_cur),
        .iir    (iir_cur)
    );

    u16550_iir u_iir_after (
        .status (status_after),
        .iir    (iir_after)
    );

    always_comb begin
        rx_head_next = rx_head_reg;
        rx_fill_next = rx_fill_reg;
        tx_head_next = tx_head_reg;
        tx_fill_next = tx_fill_reg;
        dll_next     = dll_reg;
        dlm_next     = dlm_reg;
        ier_next     = ier_reg;
        fifo_en_next = fifo_en_reg;
        lcr_next     = lcr_reg;
        mcr_next     = mcr_reg;
        scr_next     = scr_reg;
        overrun_next = overrun_reg;
        thre_next    = thre_reg;
        rx_we        = 1'b0;
        tx_we        = 1'b0;
        rdata_next   = 8'h00;
        acc_next     = 1'b0;
        txb_next     = 8'h00;
        txv_next     = 1'b0;

        case (op_reg)
            OP_READ: begin
                case (idx_reg)
                    REG_RBR: begin
                        if (dlab) begin
                            rdata_next = dll_reg;
                        end else if (rx_fill_reg != '0) begin
                            rdata_next   = rx_mem[rx_head_reg];
                            rx_head_next = rx_head_inc;
                            rx_fill_next = rx_fill_reg - 1'b1;
                        end
                    end
                    REG_IER: rdata_next = dlab ? dlm_reg : {4'b0000, ier_reg};
                    REG_IIR: begin
                        rdata_next = iir_cur;
                        if ((iir_cur & IIR_ID_MASK) == IIR_THRE) begin
                            thre_next = 1'b0;
                        end
                    end
                    REG_LCR: rdata_next = lcr_reg;
                    REG_MCR: rdata_next = {3'b000, mcr_reg};
                    REG_LSR: begin
                        rdata_next   = lsr;
                        overrun_next = 1'b0;
                    end
                    REG_MSR: rdata_next = msr;
                    default: rdata_next = scr_reg;
                endcase
            end
            OP_WRITE: begin
                acc_next = 1'b1;
                case (idx_reg)
                    REG_RBR: begin
                        if (dlab) begin
                            dll_next = wdata_reg;
                        end else if (tx_fill_reg < tx_cap) begin
                            tx_we        = 1'b1;
                            tx_fill_next = tx_fill_reg + 1'b1;
                            thre_next    = 1'b0;
                        end
                    end
                    REG_IER: begin
                        if (dlab) begin
                            dlm_next = wdata_reg;
                        end else begin
                            ier_next = wdata_reg[3:0];
                            if (!ier_reg[IER_THRE] && wdata_reg[IER_THRE]
                                && tx_fill_reg == '0) begin
                                thre_next = 1'b1;
                            end
                        end
                    end
                    REG_IIR: begin
                        if (fcr_toggle || wdata_reg[1]) begin
                            rx_head_next = '0;
                            rx_fill_next = '0;
                            overrun_next = 1'b0;
                        end
                        if (fcr_toggle || wdata_reg[2]) begin
                            tx_head_next = '0;
                            tx_fill_next = '0;
                            thre_next    = 1'b1;
                        end
                        fifo_en_next = wdata_reg[0];
                    end
                    REG_LCR: lcr_next = wdata_reg;
                    REG_MCR: mcr_next = wdata_reg[4:0];
                    REG_SCR: scr_next = wdata_reg;
                    default: ;  // LSR and MSR are read-only
                endcase
            end
            OP_RX_BYTE: begin
                if (rx_fill_reg < rx_cap) begin
                    rx_we        = 1'b1;
                    rx_fill_next = rx_fill_reg + 1'b1;
                    acc_next     = 1'b1;
                end else begin
                    overrun_next = 1'b1;
                end
            end
            OP_TX_TAKE: begin
                if (tx_fill_reg != '0) begin
                    txb_next     = tx_mem[tx_head_reg];
                    tx_head_next = tx_head_inc;
                    tx_fill_next = tx_fill_reg - 1'b1;
                    if (tx_fill_reg == TX_CNT_W'(1)) begin
                        thre_next = 1'b1;
                    end
                    acc_next = 1'b1;
                    txv_next = 1'b1;
                end
            end
            default: ;
        endcase
    end

    // handshake and UART state
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
            rx_head_reg   <= '0;
            rx_fill_reg   <= '0;
            tx_head_reg   <= '0;
            tx_fill_reg   <= '0;
            dll_reg       <= 8'h00;
            dlm_reg       <= 8'h00;
            ier_reg       <= 4'h0;
            fifo_en_reg   <= 1'b0;
            lcr_reg       <= 8'h00;
            mcr_reg       <= 5'h00;
            scr_reg       <= 8'h00;
            overrun_reg   <= 1'b0;
            thre_reg      <= 1'b1;
        end else begin
            if (s_ready) begin
                in_valid_reg <= s_valid;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (m_ready) begin
                out_valid_reg <= 1'b0;
            end
            if (advance) begin
                rx_head_reg <= rx_head_next;
                rx_fill_reg <= rx_fill_next;
                tx_head_reg <= tx_head_next;
                tx_fill_reg <= tx_fill_next;
                dll_reg     <= dll_next;
                dlm_reg     <= dlm_next;
                ier_reg     <= ier_next;
                fifo_en_reg <= fifo_en_next;
                lcr_reg     <= lcr_next;
                mcr_reg     <= mcr_next;
                scr_reg     <= scr_next;
                overrun_reg <= overrun_next;
                thre_reg    <= thre_next;
            end
        end
    end

    // payload: input capture, result register, FIFO stores
    always_ff @(posedge aclk) begin
        if (s_ready && s_valid) begin
            op_reg    <= op_t'(s_opcode);
            idx_reg   <= s_reg_index;
            wdata_reg <= s_write_data;
            rxb_reg   <= s_rx_byte;
        end
        if (advance) begin
            rdata_reg <= rdata_next;
            acc_reg   <= acc_next;
            txb_reg   <= txb_next;
            txv_reg   <= txv_next;
            irq_reg   <= !iir_after[0];
            if (rx_we) begin
                rx_mem[rx_tail] <= rxb_reg;
            end
            if (tx_we) begin
                tx_mem[tx_tail] <= wdata_reg;
            end
        end
    end

    assign m_valid     = out_valid_reg;
    assign m_read_data = rdata_reg;
    assign m_accepted  = acc_reg;
    assign m_tx_byte   = txb_reg;
    assign m_tx_valid  = txv_reg;
    assign m_irq       = irq_reg;

endmodule

`default_nettype wire
